[design/bvp_pkg.sv]
`timescale 1ns / 1ps

package bvp_pkg;

    // Sizes of the stream fields
    localparam int JOINTS           = 16;
    localparam int BELL_TABLE_DEPTH = 256;
    localparam int POSITION_WIDTH   = 16;

    localparam int JOINT_W  = 4;
    localparam int VALUE_W  = 16;
    localparam int JIDX_W   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int DIFF_W   = POSITION_WIDTH + 1;

    localparam int IN_TDATA_W  = ((JOINT_W + 2 * POSITION_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((JOINT_W + VALUE_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;

    // Progress divider: |num| * 4096 / |den|, two quotient bits per cycle
    localparam int PROG_FRAC   = 12;
    localparam int DIV_W       = POSITION_WIDTH + PROG_FRAC;
    localparam int DIV_STEPS   = (DIV_W + 1) / 2;
    localparam int DIV_W2      = 2 * DIV_STEPS;
    localparam int DIV_CNT_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int PROG_POS_MAX = 32767;
    localparam int PROG_NEG_MAX = 32768;

    // Bell lookup
    localparam int ARG_W      = 32;
    localparam int P_W        = ARG_W + $clog2(BELL_TABLE_DEPTH) + 1;
    localparam int IDX_SHIFT  = 24;
    localparam int FRAC_SHIFT = 8;
    localparam int FRAC_W     = 16;
    localparam int BELL_IDX_W = $clog2(BELL_TABLE_DEPTH + 1);
    localparam int BELL_W     = 16;
    localparam int BELL_ONE   = 65536;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Configuration registers
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLE       = 3'd0,
        REG_SCALE        = 3'd1,
        REG_SHIFT        = 3'd2,
        REG_TIME_SCALE   = 3'd3,
        REG_DRIVE_OFFSET = 3'd4
    } cfg_reg_t;

    localparam logic        ENABLE_RST       = 1'b1;
    localparam logic [15:0] SCALE_RST        = 16'd256;
    localparam logic [15:0] SHIFT_RST        = 16'd2048;
    localparam logic [15:0] TIME_SCALE_RST   = 16'd26;
    localparam logic [15:0] DRIVE_OFFSET_RST = 16'd0;

    typedef struct packed {
        logic        enable;
        logic [15:0] scale;
        logic [15:0] shift;
        logic [15:0] time_scale;
        logic [15:0] drive_offset;
    } cfg_t;

    // One classified sample handed from front to back
    typedef struct packed {
        logic [JOINT_W-1:0]       joint;
        logic signed [DIFF_W-1:0] num;
        logic signed [DIFF_W-1:0] den;
    } item_t;

    // One finished result
    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [VALUE_W-1:0] drive;
        logic               zero_span;
        logic               saturated;
    } result_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV,
        BK_ARG,
        BK_MUL,
        BK_ABS,
        BK_LOOK,
        BK_INTERP,
        BK_SUM,
        BK_SCALE,
        BK_DONE
    } back_state_t;

    // Bell table, worked out at elaboration
    typedef logic [BELL_W-1:0] bell_table_t [BELL_TABLE_DEPTH+1];

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] BELL_H  = (64'd16 << 30) / BELL_TABLE_DEPTH;

    // Shift-subtract long division for constant evaluation
    function automatic logic [63:0] const_udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // 4 s (1 - s) sampled on [0, 16], s the logistic, Q1.15
    function automatic bell_table_t bell_table_build();
        bell_table_t t;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] ek;
        logic [63:0] d;
        logic [63:0] r1;
        logic [63:0] r2;
        logic [63:0] v;
        longint      sum;
        term = Q30_ONE;
        sum  = longint'(Q30_ONE);
        for (int n = 1; n < 24; n++) begin
            term = const_udiv(term * BELL_H, Q30_ONE * 64'(n));
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end
            else begin
                sum = sum + longint'(term);
            end
        end
        e  = (sum < 0) ? 64'd0 : 64'(sum);
        ek = Q30_ONE;
        for (int k = 0; k <= BELL_TABLE_DEPTH; k++) begin
            d    = Q30_ONE + ek;
            r1   = const_udiv(ek << 30, d);
            r2   = const_udiv(64'd1 << 60, d);
            v    = (64'd4 * r1 * r2 + (64'd1 << 44)) >> 45;
            t[k] = BELL_W'(v);
            ek   = (ek * e + (64'd1 << 29)) >> 30;
        end
        return t;
    endfunction

    localparam bell_table_t BELL_TABLE = bell_table_build();

endpackage

[design/bvp_front.sv]
`timescale 1ns / 1ps

module bvp_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         enable,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [bvp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                         fifo_full,
    output logic                         push,
    output bvp_pkg::item_t               push_item
);
    import bvp_pkg::*;

    logic [JOINTS-1:0]               seen_reg;
    logic [JOINTS-1:0]               seen_next;
    logic [POSITION_WIDTH-1:0]       last_target_reg [JOINTS];
    logic [POSITION_WIDTH-1:0]       start_reg [JOINTS];

    logic [JOINT_W-1:0]              joint_w;
    logic signed [POSITION_WIDTH-1:0] cur_w;
    logic signed [POSITION_WIDTH-1:0] tgt_w;
    logic signed [POSITION_WIDTH-1:0] start_w;
    logic [JIDX_W-1:0]               jidx;
    logic                            in_range;
    logic                            restart;

    // Split the transfer into its fields
    assign joint_w  = s_axis_tdata[JOINT_W-1:0];
    assign cur_w    = s_axis_tdata[JOINT_W +: POSITION_WIDTH];
    assign tgt_w    = s_axis_tdata[JOINT_W + POSITION_WIDTH +: POSITION_WIDTH];
    assign jidx     = JIDX_W'(joint_w);
    assign in_range = (32'(joint_w) < JOINTS);

    assign s_axis_tready = !fifo_full;

    // Restart the move on a new target or a joint never seen before
    assign restart = !seen_reg[jidx] || (tgt_w != last_target_reg[jidx]);
    assign start_w = restart ? cur_w : start_reg[jidx];

    assign push = s_axis_tvalid && s_axis_tready && enable && in_range;

    always_comb
    begin
        push_item.joint = joint_w;
        push_item.num   = DIFF_W'(cur_w) - DIFF_W'(start_w);
        push_item.den   = DIFF_W'(tgt_w) - DIFF_W'(start_w);
        seen_next       = seen_reg;
        if (push) begin
            seen_next[jidx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            seen_reg <= '0;
        end
        else begin
            seen_reg <= seen_next;
        end
    end

    // Hold target and start per joint
    always_ff @(posedge clk)
    begin
        if (push) begin
            last_target_reg[jidx] <= tgt_w;
            start_reg[jidx]       <= start_w;
        end
    end

endmodule

[design/bvp_fifo.sv]
`timescale 1ns / 1ps

module bvp_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bvp_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output bvp_pkg::item_t pop_item
);
    import bvp_pkg::*;

    item_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    assign full     = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[design/bvp_back.sv]
`timescale 1ns / 1ps

module bvp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  bvp_pkg::cfg_t    cfg,
    input  logic             item_valid,
    input  bvp_pkg::item_t   item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output bvp_pkg::result_t out_result
);
    import bvp_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    logic [JOINT_W-1:0]        joint_reg, joint_next;
    logic                      neg_reg, neg_next;
    logic                      zero_reg, zero_next;
    logic                      sat_reg, sat_next;
    logic [DIV_W2-1:0]         dvd_reg, dvd_next;
    logic [DIV_W2-1:0]         quo_reg, quo_next;
    logic [POSITION_WIDTH-1:0] rem_reg, rem_next;
    logic [POSITION_WIDTH-1:0] den_reg, den_next;
    logic signed [DIFF_W-1:0]  diff_reg, diff_next;
    logic signed [32:0]        x_reg, x_next;
    logic [P_W-1:0]            p_reg, p_next;
    logic [BELL_W-1:0]         ta_reg, ta_next;
    logic [BELL_W-1:0]         tb_reg, tb_next;
    logic [FRAC_W-1:0]         f_reg, f_next;
    logic [32:0]               pa_reg, pa_next;
    logic [31:0]               pb_reg, pb_next;
    logic [16:0]               b_reg, b_next;
    logic signed [33:0]        prod_reg, prod_next;
    result_t                   res_reg, res_next;

    // Combinational helpers
    logic [POSITION_WIDTH-1:0] an_w;
    logic [POSITION_WIDTH-1:0] ad_w;
    logic [DIV_W2-1:0]         dv_w;
    logic [DIV_W2-1:0]         qv_w;
    logic [POSITION_WIDTH-1:0] rv_w;
    logic [POSITION_WIDTH:0]   rt_w;
    logic signed [15:0]        prog_w;
    logic                      prog_sat_w;
    logic signed [15:0]        shift_s;
    logic signed [15:0]        ts_s;
    logic signed [15:0]        scale_s;
    logic signed [15:0]        offset_s;
    logic signed [32:0]        ts_x;
    logic signed [32:0]        diff_x;
    logic [32:0]               u_w;
    logic [P_W-IDX_SHIFT-1:0]  idx_w;
    logic [BELL_IDX_W-1:0]     tidx_w;
    logic                      beyond_w;
    logic [16:0]               wf_w;
    logic signed [33:0]        scale_x;
    logic signed [33:0]        b_x;
    logic signed [19:0]        shifted_w;
    logic signed [19:0]        drive_w;
    logic [15:0]               drive_sat_w;
    logic                      drive_clamp_w;

    assign shift_s  = cfg.shift;
    assign ts_s     = cfg.time_scale;
    assign scale_s  = cfg.scale;
    assign offset_s = cfg.drive_offset;
    assign ts_x     = 33'(ts_s);
    assign diff_x   = 33'(diff_reg);
    assign scale_x  = 34'(scale_s);
    assign b_x      = 34'({1'b0, b_reg});

    assign an_w = POSITION_WIDTH'((item.num < 0) ? -item.num : item.num);
    assign ad_w = POSITION_WIDTH'((item.den < 0) ? -item.den : item.den);

    // Two restoring division steps
    always_comb
    begin
        dv_w = dvd_reg;
        qv_w = quo_reg;
        rv_w = rem_reg;
        rt_w = '0;
        for (int k = 0; k < 2; k++) begin
            rt_w = {rv_w, dv_w[DIV_W2-1]};
            dv_w = {dv_w[DIV_W2-2:0], 1'b0};
            if (rt_w >= {1'b0, den_reg}) begin
                rv_w = POSITION_WIDTH'(rt_w - {1'b0, den_reg});
                qv_w = {qv_w[DIV_W2-2:0], 1'b1};
            end
            else begin
                rv_w = POSITION_WIDTH'(rt_w);
                qv_w = {qv_w[DIV_W2-2:0], 1'b0};
            end
        end
    end

    // Signed, clamped progress
    always_comb
    begin
        prog_sat_w = 1'b0;
        if (neg_reg) begin
            if (quo_reg > DIV_W2'(PROG_NEG_MAX)) begin
                prog_w     = -16'sd32768;
                prog_sat_w = 1'b1;
            end
            else begin
                prog_w = -$signed(16'(quo_reg));
            end
        end
        else begin
            if (quo_reg > DIV_W2'(PROG_POS_MAX)) begin
                prog_w     = 16'sd32767;
                prog_sat_w = 1'b1;
            end
            else begin
                prog_w = $signed(16'(quo_reg));
            end
        end
    end

    // Table position and interpolation weight
    assign u_w      = (x_reg < 0) ? 33'(-x_reg) : 33'(x_reg);
    assign idx_w    = p_reg[P_W-1:IDX_SHIFT];
    assign beyond_w = (idx_w >= (P_W-IDX_SHIFT)'(BELL_TABLE_DEPTH));
    assign tidx_w   = beyond_w ? '0 : BELL_IDX_W'(idx_w);
    assign wf_w     = 17'(BELL_ONE) - 17'(f_reg);

    // Scale, offset and clamp the drive
    assign shifted_w = 20'(prod_reg >>> 15);
    assign drive_w   = shifted_w + 20'(offset_s);
    always_comb
    begin
        drive_clamp_w = 1'b0;
        drive_sat_w   = 16'(drive_w);
        if (drive_w > 20'sd32767) begin
            drive_sat_w   = 16'h7fff;
            drive_clamp_w = 1'b1;
        end
        else if (drive_w < -20'sd32768) begin
            drive_sat_w   = 16'h8000;
            drive_clamp_w = 1'b1;
        end
    end

    // Sequencer: next state and datapath loads
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        pop            = 1'b0;
        joint_next     = joint_reg;
        neg_next       = neg_reg;
        zero_next      = zero_reg;
        sat_next       = sat_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        diff_next      = diff_reg;
        x_next         = x_reg;
        p_next         = p_reg;
        ta_next        = ta_reg;
        tb_next        = tb_reg;
        f_next         = f_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        b_next         = b_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE:
            begin
                if (item_valid) begin
                    pop        = 1'b1;
                    joint_next = item.joint;
                    neg_next   = (item.num < 0) != (item.den < 0);
                    zero_next  = (item.den == '0);
                    dvd_next   = DIV_W2'({an_w, {PROG_FRAC{1'b0}}});
                    den_next   = ad_w;
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = DIV_CNT_W'(DIV_STEPS - 1);
                    state_next = (item.den == '0) ? BK_ARG : BK_DIV;
                end
            end
            BK_DIV:
            begin
                dvd_next = dv_w;
                quo_next = qv_w;
                rem_next = rv_w;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = BK_ARG;
                end
            end
            BK_ARG:
            begin
                sat_next   = prog_sat_w;
                diff_next  = DIFF_W'(prog_w) - DIFF_W'(shift_s);
                state_next = BK_MUL;
            end
            BK_MUL:
            begin
                x_next     = ts_x * diff_x;
                state_next = BK_ABS;
            end
            BK_ABS:
            begin
                p_next     = P_W'(ARG_W'(u_w)) * P_W'(BELL_TABLE_DEPTH);
                state_next = BK_LOOK;
            end
            BK_LOOK:
            begin
                ta_next    = beyond_w ? '0 : BELL_TABLE[tidx_w];
                tb_next    = beyond_w ? '0 : BELL_TABLE[tidx_w + 1'b1];
                f_next     = p_reg[FRAC_SHIFT +: FRAC_W];
                state_next = BK_INTERP;
            end
            BK_INTERP:
            begin
                pa_next    = 33'(ta_reg) * 33'(wf_w);
                pb_next    = 32'(tb_reg) * 32'(f_reg);
                state_next = BK_SUM;
            end
            BK_SUM:
            begin
                b_next     = 17'((34'(pa_reg) + 34'(pb_reg)) >> 16);
                state_next = BK_SCALE;
            end
            BK_SCALE:
            begin
                prod_next  = scale_x * b_x;
                state_next = BK_DONE;
            end
            BK_DONE:
            begin
                if (!out_valid_reg || out_ready) begin
                    res_next.joint     = joint_reg;
                    res_next.drive     = drive_sat_w;
                    res_next.zero_span = zero_reg;
                    res_next.saturated = sat_reg || drive_clamp_w;
                    out_valid_next     = 1'b1;
                    state_next         = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        joint_reg <= joint_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        sat_reg   <= sat_next;
        dvd_reg   <= dvd_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        diff_reg  <= diff_next;
        x_reg     <= x_next;
        p_reg     <= p_next;
        ta_reg    <= ta_next;
        tb_reg    <= tb_next;
        f_reg     <= f_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        b_reg     <= b_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = res_reg;

endmodule

[design/bell_velocity_profile_unit.sv]
`timescale 1ns / 1ps
// Bell velocity profile unit.
// Input stream (s_axis): one sample per transfer with a joint index and its
// current and target position. Output stream (m_axis): one drive value per
// sample, tagged with the joint, plus zero-span and saturation flags in tuser.
// Samples for joints out of range, and all samples while enable is 0, are
// taken and dropped without a result.
// The front stage keeps per-joint target and start positions and forms the
// progress numerator and denominator in the cycle of the transfer; a 4-entry
// queue feeds the back stage, which handles one sample at a time.
// Back stage: takes the sample, runs the 2-bit-per-cycle progress divider
// (skipped on a zero span), then steps through the logistic argument multiply,
// table lookup, interpolation and scaling. A new sample is taken from the
// queue only once the result of the last one is in the output register.
// The result sits in an output register; a stalled receiver holds it there,
// and the front keeps accepting samples until the queue fills.
// Reset clears the joint history, the queue and the output, and loads the
// configuration registers with their default values.
module bell_velocity_profile_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_write_en,
    input  logic [bvp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bvp_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // joint, current_position, target_position
    input  logic [bvp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bvp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // joint_out, drive
    output logic [bvp_pkg::OUT_TUSER_W-1:0] m_axis_tuser   // zero_span, saturated
);
    import bvp_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    push;
    item_t   push_item;
    logic    fifo_full;
    logic    fifo_valid;
    item_t   fifo_item;
    logic    pop;
    result_t result;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en) begin
            unique case (cfg_index)
                REG_ENABLE:       cfg_next.enable       = cfg_data[0];
                REG_SCALE:        cfg_next.scale        = cfg_data;
                REG_SHIFT:        cfg_next.shift        = cfg_data;
                REG_TIME_SCALE:   cfg_next.time_scale   = cfg_data;
                REG_DRIVE_OFFSET: cfg_next.drive_offset = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.enable       <= ENABLE_RST;
            cfg_reg.scale        <= SCALE_RST;
            cfg_reg.shift        <= SHIFT_RST;
            cfg_reg.time_scale   <= TIME_SCALE_RST;
            cfg_reg.drive_offset <= DRIVE_OFFSET_RST;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    bvp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .enable        (cfg_reg.enable),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .fifo_full     (fifo_full),
        .push          (push),
        .push_item     (push_item)
    );

    bvp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (pop),
        .valid     (fifo_valid),
        .pop_item  (fifo_item)
    );

    bvp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (fifo_valid),
        .item       (fifo_item),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // Pack the result onto the output stream
    assign m_axis_tdata = OUT_TDATA_W'({result.drive, result.joint});
    assign m_axis_tuser = {result.saturated, result.zero_span};

endmodule
